FILE: rtl/erc_pkg.sv
// shared types and codes for the epoch reclamation engine
`default_nettype none
package erc_pkg;

  localparam logic [3:0] OP_CLAIM     = 4'd0;
  localparam logic [3:0] OP_RELEASE   = 4'd1;
  localparam logic [3:0] OP_ENTER     = 4'd2;
  localparam logic [3:0] OP_EXIT      = 4'd3;
  localparam logic [3:0] OP_SUSPEND   = 4'd4;
  localparam logic [3:0] OP_RESUME    = 4'd5;
  localparam logic [3:0] OP_ATTACH    = 4'd6;
  localparam logic [3:0] OP_QUIESCENT = 4'd7;
  localparam logic [3:0] OP_OFFLINE   = 4'd8;
  localparam logic [3:0] OP_ONLINE    = 4'd9;
  localparam logic [3:0] OP_DETACH    = 4'd10;
  localparam logic [3:0] OP_RETIRE    = 4'd11;
  localparam logic [3:0] OP_POLL      = 4'd12;
  localparam logic [3:0] OP_SWITCH    = 4'd13;
  localparam logic [3:0] OP_DEPTHQ    = 4'd14;
  localparam logic [3:0] OP_UNUSED    = 4'd15;

  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_NOT_OWNED    = 4'd1;
  localparam logic [3:0] ERR_EXIT_NO_ENTR = 4'd2;
  localparam logic [3:0] ERR_HELD_SWITCH  = 4'd3;
  localparam logic [3:0] ERR_RESUME_IN    = 4'd4;
  localparam logic [3:0] ERR_ATTACH_IN    = 4'd5;
  localparam logic [3:0] ERR_LEAKED       = 4'd6;
  localparam logic [3:0] ERR_OFFLINE_IN   = 4'd7;
  localparam logic [3:0] ERR_DETACH_IN    = 4'd8;
  localparam logic [3:0] ERR_NO_SLOT      = 4'd9;
  localparam logic [3:0] ERR_QUEUE_FULL   = 4'd10;
  localparam logic [3:0] ERR_DEPTH_OVF    = 4'd11;

  localparam logic [63:0] EPOCH_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  DEPTH_MAX = 8'd255;
  localparam logic [7:0]  POLL_EVERY_RST = 8'd32;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  slot_index;
    logic [47:0] handle;
    logic [7:0]  resume_depth;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [47:0] freed_handle;
    logic [3:0]  granted_slot;
    logic [7:0]  depth_out;
    logic [3:0]  error_code;
    logic        last;
    logic [63:0] retired_count;
    logic [63:0] freed_count;
  } out_t;

  typedef struct packed {
    logic        qmode;
    logic [7:0]  depth;
    logic [63:0] epoch;
  } slot_t;

  typedef struct packed {
    logic [63:0] epoch;
    logic [47:0] handle;
  } qent_t;

endpackage
`default_nettype wire

FILE: rtl/erc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module erc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/epoch_reclamation_engine_top.sv
// top level of the epoch reclamation engine
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+----------------------------
//  input   | start, busy, in_data           | start high and busy low
//  result  | out_valid, out_data            | out_valid high (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// claim, release, rejected slot operations, null and full retires: result in the next cycle
// other slot operations: slot ram read, then modify and write back, then the result
// poll: a min scan through the slot ram, an eligibility count through the queue
// ram, then the release of the n counted handles, one result a cycle
// reset is synchronous; slot and queue rams need no clearing, the owned
// flags and the queue count mark what is meaningful
// results cannot be stalled; the result totals are the values after the item
`default_nettype none
module epoch_reclamation_engine_top #(
  parameter int NUM_SLOTS    = 16,
  parameter int RETIRE_DEPTH = 256,
  parameter int FREE_BATCH   = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire erc_pkg::in_t   in_data,
  output logic                out_valid,
  output erc_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_data
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int QW = $clog2(RETIRE_DEPTH);
  localparam int SLW = $bits(erc_pkg::slot_t);
  localparam int QEW = $bits(erc_pkg::qent_t);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEXE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CINI = 3'd3;
  localparam logic [2:0] ST_CNT  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  // queue pointer wrap, the sum stays below twice the depth
  function automatic logic [QW-1:0] qwrap(input logic [QW:0] s);
    logic [QW:0] t;
    t = s;
    if (s >= (QW+1)'(RETIRE_DEPTH)) begin
      t = s - (QW+1)'(RETIRE_DEPTH);
    end
    return t[QW-1:0];
  endfunction

  logic [2:0]           st_r, st_nxt;
  logic [3:0]           op_r, op_nxt;
  logic [SW-1:0]        sidx_r, sidx_nxt;
  logic [7:0]           rdep_r, rdep_nxt;
  logic [NUM_SLOTS-1:0] owned_r, owned_nxt;
  logic [63:0]          gepoch_r, gepoch_nxt;
  logic [QW-1:0]        head_r, head_nxt;
  logic [QW:0]          count_r, count_nxt;
  logic [7:0]           rsp_r, rsp_nxt;
  logic [63:0]          rtot_r, rtot_nxt;
  logic [63:0]          ftot_r, ftot_nxt;
  logic [7:0]           pe_r, pe_nxt;
  logic [63:0]          min_r, min_nxt;
  logic [SW:0]          sk_r, sk_nxt;
  logic                 sv_r, sv_nxt;
  logic [SW-1:0]        sd_r, sd_nxt;
  logic [QW:0]          qk_r, qk_nxt;
  logic                 qv_r, qv_nxt;
  logic [QW:0]          nf_r, nf_nxt;
  logic [QW:0]          lim_r, lim_nxt;
  logic [QW-1:0]        base_r, base_nxt;
  logic                 rsp_clr;

  // result register
  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  logic [47:0] ohnd_r, ohnd_nxt;
  logic [3:0]  ogs_r, ogs_nxt;
  logic [7:0]  odep_r, odep_nxt;
  logic [3:0]  oerr_r, oerr_nxt;
  logic        olast_r, olast_nxt;

  // ram ports
  logic                 s_we;
  logic [SW-1:0]        s_waddr, s_raddr;
  erc_pkg::slot_t       s_wdata, s_rdata;
  logic [SLW-1:0]       s_rbits;
  logic                 q_we;
  logic [QW-1:0]        q_waddr, q_raddr;
  erc_pkg::qent_t       q_wdata, q_rdata;
  logic [QEW-1:0]       q_rbits;

  // claim search
  logic          cl_found;
  logic [SW-1:0] cl_idx;

  // input decode
  logic [SW-1:0] in_sidx;
  logic          in_slot_ok;
  logic          in_slot_op;
  logic [8:0]    rsp_inc;
  logic [QW:0]   nf_inc;

  erc_ram #(.WIDTH(SLW), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rbits)
  );
  assign s_rdata = erc_pkg::slot_t'(s_rbits);

  erc_ram #(.WIDTH(QEW), .DEPTH(RETIRE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rbits)
  );
  assign q_rdata = erc_pkg::qent_t'(q_rbits);

  // lowest free slot
  always_comb begin
    cl_found = 1'b0;
    cl_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!owned_r[i]) begin
        cl_found = 1'b1;
        cl_idx   = SW'(i);
      end
    end
  end

  assign in_sidx    = SW'(in_data.slot_index);
  assign in_slot_ok = (9'(in_data.slot_index) < 9'(NUM_SLOTS)) && owned_r[in_sidx];
  assign in_slot_op = !(in_data.operation == erc_pkg::OP_CLAIM ||
                        in_data.operation == erc_pkg::OP_RETIRE ||
                        in_data.operation == erc_pkg::OP_POLL ||
                        in_data.operation == erc_pkg::OP_UNUSED);
  assign rsp_inc = 9'(rsp_r) + 9'd1;
  assign nf_inc  = nf_r + (QW+1)'(1);

  always_comb begin
    st_nxt     = st_r;
    op_nxt     = op_r;
    sidx_nxt   = sidx_r;
    rdep_nxt   = rdep_r;
    owned_nxt  = owned_r;
    gepoch_nxt = gepoch_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    rsp_nxt    = rsp_r;
    rtot_nxt   = rtot_r;
    ftot_nxt   = ftot_r;
    pe_nxt     = pe_r;
    min_nxt    = min_r;
    sk_nxt     = sk_r;
    sv_nxt     = 1'b0;
    sd_nxt     = sd_r;
    qk_nxt     = qk_r;
    qv_nxt     = 1'b0;
    nf_nxt     = nf_r;
    lim_nxt    = lim_r;
    base_nxt   = base_r;
    rsp_clr    = 1'b0;
    ov_nxt     = 1'b0;
    okind_nxt  = 1'b0;
    ohnd_nxt   = '0;
    ogs_nxt    = '0;
    odep_nxt   = '0;
    oerr_nxt   = erc_pkg::ERR_OK;
    olast_nxt  = 1'b1;
    s_we       = 1'b0;
    s_waddr    = sidx_r;
    s_wdata    = s_rdata;
    s_raddr    = in_sidx;
    q_we       = 1'b0;
    q_waddr    = qwrap({1'b0, head_r} + count_r);
    q_wdata.handle = in_data.handle;
    q_wdata.epoch  = gepoch_r;
    q_raddr    = qwrap({1'b0, base_r} + qk_r);

    if (cfg_valid) begin
      pe_nxt = cfg_data;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_data.operation;
          sidx_nxt = in_sidx;
          rdep_nxt = in_data.resume_depth;
          if (in_slot_op && !in_slot_ok) begin
            ov_nxt   = 1'b1;
            oerr_nxt = erc_pkg::ERR_NOT_OWNED;
          end else if (in_slot_op && in_data.operation == erc_pkg::OP_RELEASE) begin
            // unowned slots always read as offline
            owned_nxt[in_sidx] = 1'b0;
            ov_nxt = 1'b1;
          end else if (in_slot_op) begin
            st_nxt = ST_SEXE;
          end else begin
            case (in_data.operation)
              erc_pkg::OP_CLAIM: begin
                ov_nxt = 1'b1;
                if (!cl_found) begin
                  oerr_nxt = erc_pkg::ERR_NO_SLOT;
                end else begin
                  owned_nxt[cl_idx] = 1'b1;
                  s_we    = 1'b1;
                  s_waddr = cl_idx;
                  s_wdata = '0;
                  ogs_nxt = 4'(cl_idx);
                end
              end
              erc_pkg::OP_RETIRE: begin
                if (in_data.handle == '0) begin
                  ov_nxt = 1'b1;
                end else if (count_r >= (QW+1)'(RETIRE_DEPTH)) begin
                  ov_nxt   = 1'b1;
                  oerr_nxt = erc_pkg::ERR_QUEUE_FULL;
                end else begin
                  q_we      = 1'b1;
                  count_nxt = count_r + (QW+1)'(1);
                  rtot_nxt  = rtot_r + 64'd1;
                  if (gepoch_r != erc_pkg::EPOCH_MAX) begin
                    gepoch_nxt = gepoch_r + 64'd1;
                  end
                  rsp_nxt = rsp_inc[7:0];
                  if (rsp_inc >= {1'b0, pe_r}) begin
                    st_nxt  = ST_SCAN;
                    rsp_clr = 1'b1;
                  end else begin
                    ov_nxt = 1'b1;
                  end
                end
              end
              erc_pkg::OP_POLL: begin
                st_nxt  = ST_SCAN;
                rsp_clr = 1'b1;
              end
              default: begin
                ov_nxt = 1'b1;
              end
            endcase
          end
          if (st_nxt == ST_SCAN) begin
            min_nxt = erc_pkg::EPOCH_MAX;
            sk_nxt  = '0;
          end
        end
      end

      ST_SEXE: begin
        // read-modify-write of one slot entry
        ov_nxt = 1'b1;
        s_we   = 1'b1;
        case (op_r)
          erc_pkg::OP_ENTER: begin
            if (s_rdata.depth == erc_pkg::DEPTH_MAX) begin
              oerr_nxt = erc_pkg::ERR_DEPTH_OVF;
            end else begin
              if (s_rdata.depth == '0 && !s_rdata.qmode) s_wdata.epoch = gepoch_r;
              s_wdata.depth = s_rdata.depth + 8'd1;
            end
          end
          erc_pkg::OP_EXIT: begin
            if (s_rdata.depth == '0) begin
              oerr_nxt = erc_pkg::ERR_EXIT_NO_ENTR;
            end else begin
              s_wdata.depth = s_rdata.depth - 8'd1;
              if (s_rdata.depth == 8'd1 && !s_rdata.qmode) s_wdata.epoch = '0;
            end
          end
          erc_pkg::OP_SUSPEND: begin
            odep_nxt = s_rdata.depth;
            if (s_rdata.depth != '0) begin
              s_wdata.depth = '0;
              if (!s_rdata.qmode) s_wdata.epoch = '0;
            end
          end
          erc_pkg::OP_RESUME: begin
            if (rdep_r != '0) begin
              if (s_rdata.depth != '0) begin
                oerr_nxt = erc_pkg::ERR_RESUME_IN;
              end else begin
                if (!s_rdata.qmode) s_wdata.epoch = gepoch_r;
                s_wdata.depth = rdep_r;
              end
            end
          end
          erc_pkg::OP_ATTACH: begin
            if (s_rdata.depth != '0) begin
              oerr_nxt = erc_pkg::ERR_ATTACH_IN;
            end else begin
              s_wdata.qmode = 1'b1;
              s_wdata.epoch = gepoch_r;
            end
          end
          erc_pkg::OP_QUIESCENT: begin
            if (s_rdata.depth != '0) oerr_nxt = erc_pkg::ERR_LEAKED;
            else s_wdata.epoch = gepoch_r;
          end
          erc_pkg::OP_OFFLINE: begin
            if (s_rdata.depth != '0) oerr_nxt = erc_pkg::ERR_OFFLINE_IN;
            else s_wdata.epoch = '0;
          end
          erc_pkg::OP_ONLINE: begin
            s_wdata.epoch = gepoch_r;
          end
          erc_pkg::OP_DETACH: begin
            if (s_rdata.depth != '0) begin
              oerr_nxt = erc_pkg::ERR_DETACH_IN;
            end else begin
              s_wdata.qmode = 1'b0;
              s_wdata.epoch = '0;
            end
          end
          erc_pkg::OP_SWITCH: begin
            if (s_rdata.depth != '0) oerr_nxt = erc_pkg::ERR_HELD_SWITCH;
          end
          erc_pkg::OP_DEPTHQ: begin
            odep_nxt = s_rdata.depth;
          end
          default: begin
          end
        endcase
        st_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        // one slot read a cycle, min over announced owned slots
        s_raddr = sk_r[SW-1:0];
        if (sk_r < (SW+1)'(NUM_SLOTS)) begin
          sv_nxt = 1'b1;
          sd_nxt = sk_r[SW-1:0];
          sk_nxt = sk_r + (SW+1)'(1);
        end
        if (sv_r) begin
          if (owned_r[sd_r] && s_rdata.epoch != '0 && s_rdata.epoch < min_r) begin
            min_nxt = s_rdata.epoch;
          end
          if (sd_r == SW'(NUM_SLOTS - 1)) begin
            st_nxt = ST_CINI;
          end
        end
      end

      ST_CINI: begin
        base_nxt = head_r;
        qk_nxt   = '0;
        nf_nxt   = '0;
        if (count_r < FREE_BATCH) lim_nxt = count_r;
        else lim_nxt = (QW+1)'(FREE_BATCH);
        st_nxt = ST_CNT;
      end

      ST_CNT: begin
        // count eligible head entries, reads issued ahead of the checks
        if (qk_r < lim_r) begin
          qv_nxt = 1'b1;
          qk_nxt = qk_r + (QW+1)'(1);
        end
        if (lim_r == '0) begin
          st_nxt = ST_IDLE;
          ov_nxt = 1'b1;
        end else if (qv_r) begin
          if (q_rdata.epoch < min_r) begin
            nf_nxt = nf_inc;
            if (nf_inc == lim_r) st_nxt = ST_EMIT;
          end else if (nf_r == '0) begin
            st_nxt = ST_IDLE;
            ov_nxt = 1'b1;
          end else begin
            st_nxt = ST_EMIT;
          end
        end
        if (st_nxt == ST_EMIT) begin
          qv_nxt    = 1'b0;
          qk_nxt    = '0;
          head_nxt  = qwrap({1'b0, head_r} + nf_nxt);
          count_nxt = count_r - nf_nxt;
          ftot_nxt  = ftot_r + 64'(nf_nxt);
          lim_nxt   = nf_nxt;
          nf_nxt    = '0;
        end
      end

      ST_EMIT: begin
        // release the counted handles, one transfer a cycle
        if (qk_r < lim_r) begin
          qv_nxt = 1'b1;
          qk_nxt = qk_r + (QW+1)'(1);
        end
        if (qv_r) begin
          ov_nxt    = 1'b1;
          okind_nxt = 1'b1;
          ohnd_nxt  = q_rdata.handle;
          olast_nxt = (nf_inc == lim_r);
          nf_nxt    = nf_inc;
          if (nf_inc == lim_r) st_nxt = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (rsp_clr) rsp_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      owned_r  <= '0;
      gepoch_r <= 64'd1;
      head_r   <= '0;
      count_r  <= '0;
      rsp_r    <= '0;
      rtot_r   <= '0;
      ftot_r   <= '0;
      pe_r     <= erc_pkg::POLL_EVERY_RST;
      sv_r     <= 1'b0;
      qv_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      owned_r  <= owned_nxt;
      gepoch_r <= gepoch_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      rsp_r    <= rsp_nxt;
      rtot_r   <= rtot_nxt;
      ftot_r   <= ftot_nxt;
      pe_r     <= pe_nxt;
      sv_r     <= sv_nxt;
      qv_r     <= qv_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    sidx_r  <= sidx_nxt;
    rdep_r  <= rdep_nxt;
    min_r   <= min_nxt;
    sk_r    <= sk_nxt;
    sd_r    <= sd_nxt;
    qk_r    <= qk_nxt;
    nf_r    <= nf_nxt;
    lim_r   <= lim_nxt;
    base_r  <= base_nxt;
    okind_r <= okind_nxt;
    ohnd_r  <= ohnd_nxt;
    ogs_r   <= ogs_nxt;
    odep_r  <= odep_nxt;
    oerr_r  <= oerr_nxt;
    olast_r <= olast_nxt;
  end

  assign busy      = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;

  // totals are already final when a result is shown
  always_comb begin
    out_data.kind          = okind_r;
    out_data.freed_handle  = ohnd_r;
    out_data.granted_slot  = ogs_r;
    out_data.depth_out     = odep_r;
    out_data.error_code    = oerr_r;
    out_data.last          = olast_r;
    out_data.retired_count = rtot_r;
    out_data.freed_count   = ftot_r;
  end
endmodule
`default_nettype wire

FILE: rtl/erc_checker.sv
// port-level checker for the epoch reclamation engine and its bind
`default_nettype none
module erc_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire erc_pkg::out_t out_data
);
  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> out_data.error_code == erc_pkg::ERR_OK)
    else $error("freed transfer carries an error");

  a_freed_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> out_data.freed_handle != '0)
    else $error("null handle released");

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kind |-> out_data.last && out_data.freed_handle == '0)
    else $error("acknowledge malformed");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or result right after reset");

  a_freed_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_data.freed_count >= $past(out_data.freed_count))
    else $error("freed total went backwards");
endmodule

bind epoch_reclamation_engine_top erc_checker u_erc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
